FILE: rtl/tvsg_pkg.sv
package tvsg_pkg;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_READ  = 2'd1,
    MODE_TICK  = 2'd2,
    MODE_MIX   = 2'd3
  } tvsg_mode_e;

  localparam int unsigned NUM_CH = 3;

  // register map
  localparam logic [3:0] REG_TONE_BASE  = 4'd0;
  localparam logic [3:0] REG_NOISE_PER  = 4'd6;
  localparam logic [3:0] REG_MIXER      = 4'd7;
  localparam logic [3:0] REG_VOL_BASE   = 4'd8;
  localparam logic [3:0] REG_ENV_FINE   = 4'd11;
  localparam logic [3:0] REG_ENV_COARSE = 4'd12;
  localparam logic [3:0] REG_ENV_SHAPE  = 4'd13;
  localparam logic [3:0] REG_PORT_A     = 4'd14;
  localparam logic [3:0] REG_PORT_B     = 4'd15;

  localparam logic [7:0] PORT_READ_VAL = 8'hFF;

  typedef struct packed {
    logic        tick;
    logic        per_we;
    logic [15:0] per;
  } tvsg_tone_ctl_t;

  typedef struct packed {
    logic        tick;
    logic        per_we;
    logic [15:0] per;
    logic        shape_we;
    logic [3:0]  shape;
  } tvsg_env_ctl_t;

  // a period of zero is stored as one
  function automatic logic [15:0] fix_period(input logic [15:0] p);
    return (p == 16'd0) ? 16'd1 : p;
  endfunction

endpackage

FILE: rtl/tvsg_tone.sv
module tvsg_tone (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  tvsg_pkg::tvsg_tone_ctl_t ctl_i,
  output logic                     level_o
);
  import tvsg_pkg::*;

  logic [15:0] period_q;
  logic [19:0] count_q;
  logic        level_q;
  logic [19:0] cnt_inc;
  logic        fire;

  assign cnt_inc = count_q + 20'd1;
  assign fire    = cnt_inc >= {period_q, 4'b0000};
  assign level_o = level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= '0;
      count_q  <= '0;
      level_q  <= 1'b1;
    end else if (ctl_i.per_we) begin
      period_q <= ctl_i.per;
    end else if (ctl_i.tick && (period_q != 16'd0)) begin
      if (fire) begin
        count_q <= '0;
        level_q <= ~level_q;
      end else begin
        count_q <= cnt_inc;
      end
    end
  end

endmodule

FILE: rtl/tvsg_noise.sv
module tvsg_noise (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       tick_i,
  input  logic       per_we_i,
  input  logic [4:0] per_i,
  output logic       level_o
);
  import tvsg_pkg::*;

  logic [4:0]  period_q;
  logic [8:0]  count_q;
  logic [16:0] shift_q;
  logic        level_q;
  logic [8:0]  cnt_inc;
  logic        fire;
  logic        fb;

  assign cnt_inc = count_q + 9'd1;
  assign fire    = cnt_inc >= {period_q, 4'b0000};
  assign fb      = shift_q[0] ^ shift_q[3];
  assign level_o = level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= '0;
      count_q  <= '0;
      shift_q  <= 17'd1;
      level_q  <= 1'b1;
    end else if (per_we_i) begin
      period_q <= (per_i == 5'd0) ? 5'd1 : per_i;
    end else if (tick_i && (period_q != 5'd0)) begin
      if (fire) begin
        count_q <= '0;
        level_q <= shift_q[0];
        shift_q <= {fb, shift_q[16:1]};
      end else begin
        count_q <= cnt_inc;
      end
    end
  end

endmodule

FILE: rtl/tvsg_env.sv
module tvsg_env (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  tvsg_pkg::tvsg_env_ctl_t ctl_i,
  output logic [4:0]              level_o
);
  import tvsg_pkg::*;

  logic [15:0] period_q;
  logic [19:0] count_q;
  logic [3:0]  shape_q;
  logic [4:0]  step_q;
  logic        holding_q;
  logic        running_q;
  logic [19:0] cnt_inc;
  logic        fire;

  // shape bits: 3 continue, 2 attack, 1 alternate, 0 hold
  assign cnt_inc = count_q + 20'd1;
  assign fire    = cnt_inc >= {period_q, 4'b0000};

  always_comb begin
    if (!running_q) begin
      level_o = 5'd0;
    end else if (holding_q) begin
      level_o = (shape_q[0] && (shape_q[2] ^ shape_q[1])) ? 5'd31 : 5'd0;
    end else begin
      level_o = shape_q[2] ? step_q : ~step_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q  <= '0;
      count_q   <= '0;
      shape_q   <= '0;
      step_q    <= '0;
      holding_q <= 1'b0;
      running_q <= 1'b0;
    end else if (ctl_i.per_we) begin
      period_q <= ctl_i.per;
    end else if (ctl_i.shape_we) begin
      shape_q   <= ctl_i.shape;
      step_q    <= '0;
      count_q   <= '0;
      holding_q <= 1'b0;
      running_q <= 1'b1;
    end else if (ctl_i.tick && running_q && (period_q != 16'd0)) begin
      if (fire) begin
        count_q <= '0;
        if (!holding_q) begin
          if (step_q != 5'd31) begin
            step_q <= step_q + 5'd1;
          end else begin
            step_q <= '0;
            // end of ramp: stop, hold, turn around, or restart the ramp
            if (!shape_q[3] || shape_q[0]) begin
              holding_q <= 1'b1;
            end else if (shape_q[1]) begin
              shape_q[2] <= ~shape_q[2];
            end
          end
        end
      end else begin
        count_q <= cnt_inc;
      end
    end
  end

endmodule

FILE: rtl/tvsg_mix.sv
module tvsg_mix #(
  parameter int unsigned FULL_SCALE = 8000
) (
  input  logic                                   en_i,
  input  logic [5:0]                             mixer_i,
  input  logic [tvsg_pkg::NUM_CH-1:0][4:0]       vol_i,
  input  logic [tvsg_pkg::NUM_CH-1:0]            tone_i,
  input  logic                                   noise_i,
  input  logic [4:0]                             env_lvl_i,
  input  logic signed [15:0]                     sample_i,
  output logic signed [15:0]                     sample_o
);
  import tvsg_pkg::*;

  localparam int unsigned VolSteps = 15;
  // floor(x * DivRecip / 2^18) == x / 3 for every sum below 2^17
  localparam logic [16:0] DivRecip = 17'd87382;

  typedef logic [15:0][14:0] vol_tbl_t;

  function automatic vol_tbl_t build_tbl();
    vol_tbl_t t;
    for (int i = 0; i < 16; i++) begin
      t[i] = 15'((FULL_SCALE * i) / VolSteps);
    end
    return t;
  endfunction

  localparam vol_tbl_t VolTbl = build_tbl();

  logic [NUM_CH-1:0][14:0] amp;
  logic [16:0]             sum;
  logic [33:0]             prod;
  logic [14:0]             quot;
  logic signed [17:0]      wide;

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      logic [3:0] vol;
      logic       on;
      vol = vol_i[ch][4] ? env_lvl_i[4:1] : vol_i[ch][3:0];
      on  = (mixer_i[ch] | tone_i[ch]) & (mixer_i[ch+3] | noise_i);
      amp[ch] = on ? VolTbl[vol] : 15'd0;
    end
  end

  assign sum  = 17'(amp[0]) + 17'(amp[1]) + 17'(amp[2]);
  assign prod = 34'(sum) * 34'(DivRecip);
  assign quot = prod[32:18];
  assign wide = 18'(sample_i) + $signed({3'b000, quot});

  always_comb begin
    if (!en_i) begin
      sample_o = sample_i;
    end else if (wide[17:15] == 3'b000 || wide[17:15] == 3'b111) begin
      sample_o = wide[15:0];
    end else if (wide[17]) begin
      sample_o = 16'sh8000;
    end else begin
      sample_o = 16'sh7FFF;
    end
  end

endmodule

FILE: rtl/three_voice_tone_noise_sound_gen.sv
// path: single input register, then result register, which loads when the output is free
// throughput: one item per cycle while the output side is free, set by the register pair
// every item, tick or mix included, is resolved in one pass through the datapath
// reset: asynchronous, clears regs_q, counters and handshake state; generator enabled
module three_voice_tone_noise_sound_gen #(
  parameter int unsigned FULL_SCALE = 8000
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         mode_i,
  input  logic [3:0]         reg_addr_i,
  input  logic [7:0]         write_data_i,
  input  logic signed [15:0] in_sample_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         read_data_o,
  output logic signed [15:0] out_sample_o
);
  import tvsg_pkg::*;

  logic               gen_en_q;
  logic               in_vld_q;
  tvsg_mode_e         mode_q;
  logic [3:0]         addr_q;
  logic [7:0]         data_q;
  logic signed [15:0] sample_q;
  logic               out_vld_q;
  logic [7:0]         rd_q, rd_d;
  logic signed [15:0] smp_q, smp_d;
  logic [7:0]         regs_q [16];

  logic advance;
  logic op_wr;
  logic op_tick;

  tvsg_tone_ctl_t          tone_ctl [NUM_CH];
  tvsg_env_ctl_t           env_ctl;
  logic [NUM_CH-1:0]       tone_lvl;
  logic [NUM_CH-1:0][4:0]  vol_regs;
  logic                    noise_lvl;
  logic [4:0]              env_lvl;
  logic signed [15:0]      mix_smp;

  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;
  assign op_wr      = advance && (mode_q == MODE_WRITE);
  assign op_tick    = advance && (mode_q == MODE_TICK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_en_q <= 1'b1;
    end else if (cfg_we_i) begin
      gen_en_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      mode_q   <= tvsg_mode_e'(mode_i);
      addr_q   <= reg_addr_i;
      data_q   <= write_data_i;
      sample_q <= in_sample_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) begin
        regs_q[i] <= '0;
      end
    end else if (op_wr) begin
      regs_q[addr_q] <= data_q;
    end
  end

  // period writes combine the new byte with its stored partner
  for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_tone
    localparam logic [3:0] FineReg   = REG_TONE_BASE + 4'(2 * ch);
    localparam logic [3:0] CoarseReg = FineReg + 4'd1;

    assign tone_ctl[ch].tick   = op_tick;
    assign tone_ctl[ch].per_we = op_wr && (addr_q == FineReg || addr_q == CoarseReg);
    assign tone_ctl[ch].per    = fix_period((addr_q == FineReg) ?
                                            {regs_q[CoarseReg], data_q} :
                                            {data_q, regs_q[FineReg]});
    assign vol_regs[ch]        = regs_q[REG_VOL_BASE + 4'(ch)][4:0];

    tvsg_tone u_tone (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (tone_ctl[ch]),
      .level_o (tone_lvl[ch])
    );
  end

  tvsg_noise u_noise (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tick_i   (op_tick),
    .per_we_i (op_wr && (addr_q == REG_NOISE_PER)),
    .per_i    (data_q[4:0]),
    .level_o  (noise_lvl)
  );

  assign env_ctl.tick     = op_tick;
  assign env_ctl.per_we   = op_wr && (addr_q == REG_ENV_FINE || addr_q == REG_ENV_COARSE);
  assign env_ctl.per      = fix_period((addr_q == REG_ENV_FINE) ?
                                       {regs_q[REG_ENV_COARSE], data_q} :
                                       {data_q, regs_q[REG_ENV_FINE]});
  assign env_ctl.shape_we = op_wr && (addr_q == REG_ENV_SHAPE);
  assign env_ctl.shape    = data_q[3:0];

  tvsg_env u_env (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (env_ctl),
    .level_o (env_lvl)
  );

  tvsg_mix #(
    .FULL_SCALE (FULL_SCALE)
  ) u_mix (
    .en_i      (gen_en_q),
    .mixer_i   (regs_q[REG_MIXER][5:0]),
    .vol_i     (vol_regs),
    .tone_i    (tone_lvl),
    .noise_i   (noise_lvl),
    .env_lvl_i (env_lvl),
    .sample_i  (sample_q),
    .sample_o  (mix_smp)
  );

  always_comb begin
    rd_d  = '0;
    smp_d = '0;
    if (mode_q == MODE_READ) begin
      rd_d = (addr_q == REG_PORT_A || addr_q == REG_PORT_B) ? PORT_READ_VAL : regs_q[addr_q];
    end
    if (mode_q == MODE_MIX) begin
      smp_d = mix_smp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      rd_q  <= rd_d;
      smp_q <= smp_d;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign read_data_o  = rd_q;
  assign out_sample_o = smp_q;

endmodule

FILE: rtl/tvsg_chk.sv
module tvsg_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [7:0]         read_data_o,
  input logic signed [15:0] out_sample_o
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_data_o) && $stable(out_sample_o))
    else $error("result changed or dropped while stalled");

  // with nothing waiting at the output the input side never stalls
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

  // every accepted item is followed by a valid result at the output
  a_item_reaches_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |-> ##2 out_valid_o)
    else $error("accepted item did not reach the output");

  // an edge seen in reset leaves the output empty
  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result valid during reset");

endmodule

bind three_voice_tone_noise_sound_gen tvsg_chk u_tvsg_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .read_data_o  (read_data_o),
  .out_sample_o (out_sample_o)
);

FILE: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import tvsg_pkg::*;

  localparam int unsigned FULL_SCALE = 8000;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct {
    logic [7:0]        rd;
    logic signed [15:0] smp;
  } psg_out_t;

  typedef struct {
    bit       pinned;
    psg_out_t want;
  } pin_t;

  typedef struct {
    tvsg_mode_e         mode;
    logic [3:0]         addr;
    logic [7:0]         data;
    logic signed [15:0] smp;
    int                 reps;
    bit                 pinned;
    logic [7:0]         rd;
    logic signed [15:0] so;
  } plan_row_t;

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic               cfg_wdata_i = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [1:0]         mode_i = MODE_READ;
  logic [3:0]         reg_addr_i = '0;
  logic [7:0]         write_data_i = '0;
  logic signed [15:0] in_sample_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [7:0]         read_data_o;
  logic signed [15:0] out_sample_o;

  three_voice_tone_noise_sound_gen #(
    .FULL_SCALE(FULL_SCALE)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .reg_addr_i  (reg_addr_i),
    .write_data_i(write_data_i),
    .in_sample_i (in_sample_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .read_data_o (read_data_o),
    .out_sample_o(out_sample_o)
  );

  // shadow copy of the generator state
  logic [7:0]  psg_regs [16];
  logic [15:0] tone_per [3];
  logic [19:0] tone_cnt [3];
  logic        tone_lvl [3];
  logic [4:0]  nz_per;
  logic [8:0]  nz_cnt;
  logic [16:0] nz_lfsr;
  logic        nz_lvl;
  logic [15:0] env_per;
  logic [19:0] env_cnt;
  logic [3:0]  env_shp;
  logic [4:0]  env_pos;
  logic        env_frozen;
  logic        env_run;
  logic        gen_en;

  psg_out_t    pending_out [$];
  pin_t        pin_q [$];
  plan_row_t   plan [$];

  int unsigned errors;
  int unsigned cycles;
  int unsigned issued;
  int unsigned stall_left;
  int unsigned stall_roll;
  bit          calm;
  psg_out_t    mon_pred;
  psg_out_t    mon_exp;
  pin_t        mon_pin;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic void shadow_reset();
    int i;
    for (i = 0; i < 16; i++) psg_regs[i] = 8'h00;
    for (i = 0; i < 3; i++) begin
      tone_per[i] = '0;
      tone_cnt[i] = '0;
      tone_lvl[i] = 1'b1;
    end
    nz_per = '0;
    nz_cnt = '0;
    nz_lfsr = 17'd1;
    nz_lvl = 1'b1;
    env_per = '0;
    env_cnt = '0;
    env_shp = '0;
    env_pos = '0;
    env_frozen = 1'b0;
    env_run = 1'b0;
    gen_en = 1'b1;
  endfunction

  function automatic void reg_write(logic [3:0] a, logic [7:0] v);
    logic [15:0] pair;
    psg_regs[a] = v;
    if (a < REG_NOISE_PER) begin
      pair = {psg_regs[{a[3:1], 1'b1}], psg_regs[{a[3:1], 1'b0}]};
      tone_per[a[3:1]] = (pair == 16'd0) ? 16'd1 : pair;
    end else begin
      case (a)
        REG_NOISE_PER: nz_per = (v[4:0] == 5'd0) ? 5'd1 : v[4:0];
        REG_ENV_FINE, REG_ENV_COARSE: begin
          pair = {psg_regs[REG_ENV_COARSE], psg_regs[REG_ENV_FINE]};
          env_per = (pair == 16'd0) ? 16'd1 : pair;
        end
        REG_ENV_SHAPE: begin
          // any shape write restarts the envelope from step zero
          env_shp = v[3:0];
          env_pos = '0;
          env_frozen = 1'b0;
          env_run = 1'b1;
          env_cnt = '0;
        end
        default: ;
      endcase
    end
  endfunction

  function automatic logic [4:0] env_level();
    logic attack;
    logic alt;
    attack = env_shp[2];
    alt = env_shp[1];
    if (!env_run) return 5'd0;
    if (env_frozen) return (env_shp[0] && (attack != alt)) ? 5'd31 : 5'd0;
    return attack ? env_pos : 5'd31 - env_pos;
  endfunction

  function automatic void tick_all();
    int   ch;
    logic fb;
    for (ch = 0; ch < 3; ch++) begin
      if (tone_per[ch] != 16'd0) begin
        tone_cnt[ch] = tone_cnt[ch] + 20'd1;
        if (tone_cnt[ch] >= {tone_per[ch], 4'd0}) begin
          tone_cnt[ch] = '0;
          tone_lvl[ch] = ~tone_lvl[ch];
        end
      end
    end
    if (nz_per != 5'd0) begin
      nz_cnt = nz_cnt + 9'd1;
      if (nz_cnt >= {nz_per, 4'd0}) begin
        fb = nz_lfsr[0] ^ nz_lfsr[3];
        nz_cnt = '0;
        nz_lvl = nz_lfsr[0];
        nz_lfsr = {fb, nz_lfsr[16:1]};
      end
    end
    if (env_run && env_per != 16'd0) begin
      env_cnt = env_cnt + 20'd1;
      if (env_cnt >= {env_per, 4'd0}) begin
        env_cnt = '0;
        if (!env_frozen) begin
          if (env_pos < 5'd31) begin
            env_pos = env_pos + 5'd1;
          end else begin
            env_pos = '0;
            // hold on wrap unless continue without hold; alternate flips direction
            if (!env_shp[3] || env_shp[0]) env_frozen = 1'b1;
            else if (env_shp[1]) env_shp[2] = ~env_shp[2];
          end
        end
      end
    end
  endfunction

  function automatic logic signed [15:0] mix_expect(logic signed [15:0] smp);
    int         acc;
    int         total;
    int         ch;
    logic [7:0] vr;
    logic [4:0] vol;
    bit         audible;
    if (!gen_en) return smp;
    total = 0;
    for (ch = 0; ch < 3; ch++) begin
      vr = psg_regs[REG_VOL_BASE + ch];
      vol = vr[4] ? (env_level() >> 1) : {1'b0, vr[3:0]};
      audible = (psg_regs[REG_MIXER][ch] || tone_lvl[ch]) &&
                (psg_regs[REG_MIXER][ch + 3] || nz_lvl);
      if (audible) total += int'((FULL_SCALE * vol) / 15);
    end
    acc = int'(smp) + total / 3;
    if (acc > 32767) acc = 32767;
    if (acc < -32768) acc = -32768;
    return acc[15:0];
  endfunction

  function automatic psg_out_t predict_psg(logic [1:0] m, logic [3:0] a, logic [7:0] d,
                                           logic signed [15:0] s);
    psg_out_t r;
    r.rd = 8'h00;
    r.smp = '0;
    case (tvsg_mode_e'(m))
      MODE_WRITE: reg_write(a, d);
      MODE_READ:  r.rd = (a == REG_PORT_A || a == REG_PORT_B) ? PORT_READ_VAL : psg_regs[a];
      MODE_TICK:  tick_all();
      default:    r.smp = mix_expect(s);
    endcase
    return r;
  endfunction

  function automatic int pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic logic signed [15:0] rand_sample();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 16'sh7FFF;
    if (roll == 1) return 16'sh8000;
    return 16'($urandom);
  endfunction

  // item is held until the handshake; valid stays up for a back-to-back item
  task automatic drive_item(tvsg_mode_e m, logic [3:0] a, logic [7:0] d,
                            logic signed [15:0] s, bit pinned, logic [7:0] rd,
                            logic signed [15:0] so);
    int   gap;
    pin_t p;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= m;
    reg_addr_i <= a;
    write_data_i <= d;
    in_sample_i <= s;
    p.pinned = pinned;
    p.want.rd = rd;
    p.want.smp = so;
    pin_q.push_back(p);
    issued++;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic issue(tvsg_mode_e m, logic [3:0] a, logic [7:0] d, logic signed [15:0] s);
    drive_item(m, a, d, s, 1'b0, 8'h00, 16'sd0);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_out.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_enable(logic v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    gen_en = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_directed();
    plan_row_t row;
    // reset state, ports and the mix extremes
    plan.push_back('{MODE_READ, REG_TONE_BASE, 8'h00, 16'sd0, 1, 1'b1, 8'h00, 16'sd0});
    plan.push_back('{MODE_READ, REG_PORT_A, 8'h00, 16'sd0, 1, 1'b1, PORT_READ_VAL, 16'sd0});
    plan.push_back('{MODE_READ, REG_PORT_B, 8'h00, 16'sd0, 1, 1'b1, PORT_READ_VAL, 16'sd0});
    plan.push_back('{MODE_MIX, 4'd0, 8'h00, 16'sd0, 1, 1'b1, 8'h00, 16'sd0});
    plan.push_back('{MODE_MIX, 4'd0, 8'h00, 16'sh7FFF, 1, 1'b1, 8'h00, 16'sh7FFF});
    plan.push_back('{MODE_MIX, 4'd0, 8'h00, 16'sh8000, 1, 1'b1, 8'h00, 16'sh8000});
    plan.push_back('{MODE_TICK, 4'd0, 8'h00, 16'sd0, 1, 1'b1, 8'h00, 16'sd0});
    plan.push_back('{MODE_WRITE, REG_VOL_BASE, 8'h0F, 16'sd0, 1, 1'b1, 8'h00, 16'sd0});
    plan.push_back('{MODE_READ, REG_VOL_BASE, 8'h00, 16'sd0, 1, 1'b1, 8'h0F, 16'sd0});
    // full volume on an idle channel saturates at the top
    plan.push_back('{MODE_MIX, 4'd0, 8'h00, 16'sh7FFF, 1, 1'b1, 8'h00, 16'sh7FFF});
    plan.push_back('{MODE_MIX, 4'd0, 8'h00, 16'sd0, 1, 1'b1, 8'h00, 16'sd2666});
    // zero period becomes one, so tone A toggles after 16 ticks
    plan.push_back('{MODE_WRITE, REG_TONE_BASE, 8'h00, 16'sd0, 1, 1'b1, 8'h00, 16'sd0});
    plan.push_back('{MODE_TICK, 4'd0, 8'h00, 16'sd0, 16, 1'b1, 8'h00, 16'sd0});
    plan.push_back('{MODE_MIX, 4'd0, 8'h00, 16'sd0, 1, 1'b0, 8'h00, 16'sd0});
    // tone and noise both disabled still sounds
    plan.push_back('{MODE_WRITE, REG_MIXER, 8'h09, 16'sd0, 1, 1'b0, 8'h00, 16'sd0});
    plan.push_back('{MODE_MIX, 4'd0, 8'h00, -16'sd100, 1, 1'b0, 8'h00, 16'sd0});
    plan.push_back('{MODE_WRITE, REG_NOISE_PER, 8'hFF, 16'sd0, 1, 1'b0, 8'h00, 16'sd0});
    plan.push_back('{MODE_WRITE, REG_VOL_BASE + 4'd1, 8'hFF, 16'sd0, 1, 1'b0, 8'h00, 16'sd0});
    plan.push_back('{MODE_WRITE, REG_ENV_FINE, 8'h00, 16'sd0, 1, 1'b0, 8'h00, 16'sd0});
    plan.push_back('{MODE_WRITE, REG_ENV_SHAPE, 8'h0D, 16'sd0, 1, 1'b0, 8'h00, 16'sd0});
    plan.push_back('{MODE_TICK, 4'd0, 8'h00, 16'sd0, 40, 1'b0, 8'h00, 16'sd0});
    plan.push_back('{MODE_MIX, 4'd0, 8'h00, 16'sd1234, 1, 1'b0, 8'h00, 16'sd0});
    plan.push_back('{MODE_WRITE, REG_TONE_BASE + 4'd1, 8'hFF, 16'sd0, 1, 1'b0, 8'h00, 16'sd0});
    plan.push_back('{MODE_READ, REG_TONE_BASE + 4'd1, 8'h00, 16'sd0, 1, 1'b1, 8'hFF, 16'sd0});
    plan.push_back('{MODE_WRITE, REG_PORT_A, 8'h55, 16'sd0, 1, 1'b0, 8'h00, 16'sd0});
    plan.push_back('{MODE_READ, REG_PORT_A, 8'h00, 16'sd0, 1, 1'b1, PORT_READ_VAL, 16'sd0});
    // decay shape restarted mid-ramp
    plan.push_back('{MODE_WRITE, REG_ENV_SHAPE, 8'h00, 16'sd0, 1, 1'b0, 8'h00, 16'sd0});
    plan.push_back('{MODE_TICK, 4'd0, 8'h00, 16'sd0, 20, 1'b0, 8'h00, 16'sd0});
    plan.push_back('{MODE_MIX, 4'd0, 8'h00, 16'sd0, 1, 1'b0, 8'h00, 16'sd0});
    foreach (plan[i]) begin
      row = plan[i];
      repeat (row.reps) drive_item(row.mode, row.addr, row.data, row.smp, row.pinned,
                                   row.rd, row.so);
    end
  endtask

  task automatic tick_burst(int n, int mix_odds);
    repeat (n) begin
      if ($urandom_range(0, mix_odds - 1) == 0)
        issue(MODE_MIX, 4'($urandom), 8'($urandom), rand_sample());
      else issue(MODE_TICK, 4'($urandom), 8'($urandom), 16'($urandom));
    end
  endtask

  task automatic random_phase(int unsigned n);
    int unsigned start;
    int unsigned roll;
    int unsigned ch;
    logic [3:0]  base;
    start = issued;
    while (issued - start < n) begin
      roll = $urandom_range(0, 99);
      calm = ($urandom_range(0, 5) == 0);
      if (roll < 45) begin
        // short tone period, then let it run
        ch = $urandom_range(0, 2);
        base = REG_TONE_BASE + 4'(2 * ch);
        issue(MODE_WRITE, base, 8'($urandom_range(0, 3)), rand_sample());
        issue(MODE_WRITE, base + 4'd1,
              ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : 8'h00,
              rand_sample());
        if ($urandom_range(0, 2) == 0) issue(MODE_WRITE, REG_NOISE_PER, 8'($urandom), 16'sd0);
        if ($urandom_range(0, 2) == 0) issue(MODE_WRITE, REG_MIXER, 8'($urandom), 16'sd0);
        if ($urandom_range(0, 1) == 0)
          issue(MODE_WRITE, REG_VOL_BASE + 4'(ch), 8'($urandom), 16'sd0);
        tick_burst($urandom_range(4, 60), 4);
      end else if (roll < 60) begin
        repeat ($urandom_range(1, 6))
          issue(tvsg_mode_e'($urandom_range(0, 3)), 4'($urandom), 8'($urandom),
                rand_sample());
      end else if (roll < 75) begin
        repeat ($urandom_range(1, 4))
          issue(MODE_READ, 4'($urandom), 8'($urandom), rand_sample());
      end else if (roll < 92) begin
        repeat ($urandom_range(1, 4))
          issue(MODE_MIX, 4'($urandom), 8'($urandom), rand_sample());
      end else begin
        drain();
      end
    end
    calm = 1'b0;
  endtask

  // fastest envelope, a few steps into the ramp
  task automatic envelope_run();
    int ch;
    issue(MODE_WRITE, REG_ENV_FINE, 8'($urandom_range(0, 1)), 16'sd0);
    issue(MODE_WRITE, REG_ENV_COARSE, 8'h00, 16'sd0);
    for (ch = 0; ch < 3; ch++)
      issue(MODE_WRITE, REG_VOL_BASE + 4'(ch), 8'h10 | 8'($urandom_range(0, 31)), 16'sd0);
    issue(MODE_WRITE, REG_MIXER, ($urandom_range(0, 1) == 0) ? 8'h3F : 8'($urandom), 16'sd0);
    issue(MODE_WRITE, REG_ENV_SHAPE, 8'($urandom), 16'sd0);
    calm = ($urandom_range(0, 1) == 0);
    tick_burst(48, 8);
    calm = 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (calm) begin
      out_ready_i <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready_i <= 1'b1;
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 15) stall_left <= $urandom_range(1, 3);
      else if (stall_roll < 18) stall_left <= $urandom_range(8, 40);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        mon_pred = predict_psg(mode_i, reg_addr_i, write_data_i, in_sample_i);
        mon_pin = pin_q.pop_front();
        pending_out.push_back(mon_pin.pinned ? mon_pin.want : mon_pred);
      end
      if (out_valid_o && out_ready_i) begin
        if (pending_out.size() == 0) begin
          errors++;
          $display("%0t: unexpected item read_data %02h out_sample %0d", $time,
                   read_data_o, out_sample_o);
        end else begin
          mon_exp = pending_out.pop_front();
          if (read_data_o !== mon_exp.rd) begin
            errors++;
            $display("%0t: read_data expected %02h got %02h", $time, mon_exp.rd,
                     read_data_o);
          end
          if (out_sample_o !== mon_exp.smp) begin
            errors++;
            $display("%0t: out_sample expected %0d got %0d", $time, mon_exp.smp,
                     out_sample_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("three_voice_tone_noise_sound_gen verification failed");
      $finish;
    end
  end

  initial begin
    shadow_reset();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_enable(1'b1);
    run_directed();
    random_phase(100);
    envelope_run();
    set_enable(1'b0);
    random_phase(30);
    set_enable(1'b1);
    random_phase(30);
    envelope_run();
    drain();
    repeat (6) @(posedge clk_i);
    if (errors == 0) $display("three_voice_tone_noise_sound_gen verification clean");
    else $display("three_voice_tone_noise_sound_gen verification failed");
    $finish;
  end

endmodule
